>>> rtl/frame_rate_window_stats_macros.svh
// assertion macros shared by the checker
`ifndef FRAME_RATE_WINDOW_STATS_MACROS_SVH
`define FRAME_RATE_WINDOW_STATS_MACROS_SVH
// implication checked on every edge outside reset
`define FRWS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frws check failed");
// implication checked in the cycle after the antecedent
`define FRWS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frws check failed");
`endif

>>> rtl/frws_pkg.sv
// shared types and constants for the frame rate window statistics block
package frws_pkg;
  localparam logic [27:0] RATE_SCALE = 28'd256000000;
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // division steps, in the order they run
  localparam logic [1:0] DIV_CURRENT = 2'd0;
  localparam logic [1:0] DIV_AVERAGE = 2'd1;
  localparam logic [1:0] DIV_MIN     = 2'd2;
  localparam logic [1:0] DIV_MAX     = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_UPDATE, ST_SCAN, ST_DIV, ST_OUT
  } frws_state_t;

  // divider request bundle
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [37:0] den;
  } frws_div_req_t;

  typedef struct packed {
    logic        done;
    logic [27:0] quo;
  } frws_div_rsp_t;
endpackage

>>> rtl/frws_in_if.sv
// input channel: opcode and timestamp
interface frws_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] timestamp_us;
  modport source (output valid, opcode, timestamp_us, input ready);
  modport sink (input valid, opcode, timestamp_us, output ready);
endinterface

>>> rtl/frws_out_if.sv
// output channel: rate statistics
interface frws_out_if;
  logic        valid;
  logic        ready;
  logic [27:0] current_fps;
  logic [27:0] average_fps;
  logic [27:0] min_fps;
  logic [27:0] max_fps;
  logic [6:0]  samples_held;
  modport source (output valid, current_fps, average_fps, min_fps, max_fps, samples_held,
                  input ready);
  modport sink (input valid, current_fps, average_fps, min_fps, max_fps, samples_held,
                output ready);
endinterface

>>> rtl/frws_ram.sv
// generic single port ram with registered read
module frws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> rtl/frws_div.sv
// restoring divider, one quotient bit per cycle, 28-bit quotient
module frws_div (
  input  logic                    clk,
  input  logic                    rst,
  input  frws_pkg::frws_div_req_t req,
  output frws_pkg::frws_div_rsp_t rsp
);
  import frws_pkg::*;

  logic [63:0] num;
  logic [37:0] den;
  logic [38:0] rem;
  logic [27:0] quo;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;
  logic [38:0] trial;
  logic [38:0] shifted;

  // quotient fits 28 bits, so remainder stays below 2*den
  assign shifted = {rem[37:0], num[63]};
  assign trial   = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
        num  <= req.num;
        den  <= req.den;
        rem  <= '0;
      end else if (busy) begin
        num <= {num[62:0], 1'b0};
        if (!trial[38]) begin
          rem <= trial;
        end else begin
          rem <= shifted;
        end
        quo <= {quo[26:0], !trial[38]};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // response bundle
  assign rsp = '{done: done, quo: quo};
endmodule

>>> rtl/frame_rate_window_stats.sv
// frame rate window statistics top level
//   channel | role   | beat
//   in      | sink   | opcode, timestamp_us
//   out     | source | current_fps, average_fps, min_fps, max_fps, samples_held
// one beat at a time: accept, ring update, scan of held entries, four divisions.
// a clear or zero interval skips the current-rate division, an empty window the others.
// rst is synchronous; the ring needs no clearing since only written slots are read.
// a result waits in the output register; in.ready is low until it is taken.
module frame_rate_window_stats #(
  parameter int WINDOW = 64
) (
  input logic        clk,
  input logic        rst,
  frws_in_if.sink    in,
  frws_out_if.source out
);
  import frws_pkg::*;

  localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW = $clog2(WINDOW + 1);

  frws_state_t state, state_next;
  logic [AW-1:0] write_slot;
  logic [CW-1:0] held_count;
  logic [37:0]   interval_sum;
  logic [31:0]   previous_stamp;
  logic [27:0]   last_rate;
  logic          op;
  logic [31:0]   iv;
  logic [CW-1:0] scan_idx;
  logic          scan_pend;
  logic [31:0]   lo, hi;
  logic [1:0]    div_sel;
  logic          div_wait;
  logic          div_need;
  logic          div_step;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [31:0]   ram_rdata;
  frws_div_req_t dreq;
  frws_div_rsp_t drsp;

  frws_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_ring (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(iv), .rdata(ram_rdata)
  );

  frws_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // division step: a needed division finished or an unneeded one skipped
  always_comb begin
    if (div_sel == DIV_CURRENT) begin
      div_need = (op == OP_FRAME) && (iv != '0);
    end else begin
      div_need = (held_count != '0);
    end
    div_step = div_wait ? drsp.done : !div_need;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in.valid && in.ready) state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_SCAN;
      ST_SCAN:   if (scan_idx == held_count && !scan_pend) state_next = ST_DIV;
      ST_DIV:    if (div_sel == DIV_MAX && div_step) state_next = ST_OUT;
      ST_OUT:    if (out.ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in.ready = (state == ST_IDLE) && !out.valid;
    ram_we   = (state == ST_UPDATE) && (op == OP_FRAME) && (iv != '0);
    ram_addr = (state == ST_SCAN) ? scan_idx[AW-1:0] : write_slot;
  end

  // divider request and operand selection
  always_comb begin
    dreq.start = (state == ST_DIV) && !div_wait && div_need;
    dreq.num   = 64'(RATE_SCALE);
    dreq.den   = 38'(iv);
    unique case (div_sel)
      DIV_CURRENT: dreq.den = 38'(iv);
      DIV_AVERAGE: begin
        dreq.num = 64'(40'(RATE_SCALE) * 40'(held_count));
        dreq.den = interval_sum;
      end
      DIV_MIN:     dreq.den = 38'(hi);
      DIV_MAX:     dreq.den = 38'(lo);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      write_slot     <= '0;
      held_count     <= '0;
      interval_sum   <= '0;
      previous_stamp <= '0;
      last_rate      <= '0;
      out.valid      <= 1'b0;
      div_wait       <= 1'b0;
      div_sel        <= DIV_CURRENT;
      scan_pend      <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        // capture input beat
        ST_IDLE: begin
          if (in.valid && in.ready) begin
            op <= in.opcode;
            iv <= in.timestamp_us - previous_stamp;
            previous_stamp <= in.timestamp_us;
          end
        end
        // ring write of the new interval, or clear
        ST_UPDATE: begin
          if (op == OP_CLEAR) begin
            held_count <= '0;
            write_slot <= '0;
            last_rate  <= '0;
          end else if (iv != '0) begin
            if (write_slot == AW'(WINDOW - 1)) begin
              write_slot <= '0;
            end else begin
              write_slot <= write_slot + AW'(1);
            end
            if (held_count != CW'(WINDOW)) held_count <= held_count + CW'(1);
          end
          scan_idx        <= '0;
          scan_pend       <= 1'b0;
          lo              <= '1;
          hi              <= '0;
          interval_sum    <= '0;
          div_sel         <= DIV_CURRENT;
          div_wait        <= 1'b0;
          out.average_fps <= '0;
          out.min_fps     <= '0;
          out.max_fps     <= '0;
        end
        // sum, min and max over held slots 0..held_count-1
        ST_SCAN: begin
          if (scan_pend) begin
            if (ram_rdata < lo) lo <= ram_rdata;
            if (ram_rdata > hi) hi <= ram_rdata;
            interval_sum <= interval_sum + 38'(ram_rdata);
          end
          if (scan_idx != held_count) begin
            scan_idx  <= scan_idx + CW'(1);
            scan_pend <= 1'b1;
          end else begin
            scan_pend <= 1'b0;
          end
        end
        // four divisions: current, average, min, max
        ST_DIV: begin
          if (!div_wait && div_need) begin
            div_wait <= 1'b1;
          end else if (div_step) begin
            div_wait <= 1'b0;
            div_sel  <= div_sel + 2'd1;
            if (div_wait) begin
              unique case (div_sel)
                DIV_CURRENT: last_rate <= drsp.quo;
                DIV_AVERAGE: out.average_fps <= drsp.quo;
                DIV_MIN:     out.min_fps <= drsp.quo;
                DIV_MAX:     out.max_fps <= drsp.quo;
              endcase
            end
            if (div_sel == DIV_MAX) begin
              out.valid        <= 1'b1;
              out.current_fps  <= last_rate;
              out.samples_held <= 7'(held_count);
            end
          end
        end
        // hold the result until taken
        ST_OUT: begin
          if (out.ready) out.valid <= 1'b0;
        end
        default: ;
      endcase
    end
  end
endmodule

>>> rtl/frws_check.sv
// port-level checker for the statistics block, bound to the top level
`include "frame_rate_window_stats_macros.svh"
module frws_check (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [27:0] average_fps,
  input logic [27:0] min_fps,
  input logic [27:0] max_fps,
  input logic [6:0]  samples_held
);
  // no new input while a result waits
  `FRWS_ASSERT_IMP(a_no_accept_busy, clk, rst, out_valid, !in_ready)
  // empty window gives zero rates
  `FRWS_ASSERT_IMP(a_empty_zero, clk, rst, out_valid && samples_held == 7'd0,
    average_fps == 28'd0 && min_fps == 28'd0 && max_fps == 28'd0)
  // min rate never exceeds max rate
  `FRWS_ASSERT_IMP(a_order, clk, rst, out_valid, min_fps <= max_fps)
  // accepted input produces no result in the next cycle
  `FRWS_ASSERT_NEXT(a_latency, clk, rst, in_valid && in_ready, !out_valid)
endmodule

bind frame_rate_window_stats frws_check u_check (
  .clk(clk), .rst(rst), .in_valid(in.valid), .in_ready(in.ready),
  .out_valid(out.valid), .out_ready(out.ready), .average_fps(out.average_fps),
  .min_fps(out.min_fps), .max_fps(out.max_fps), .samples_held(out.samples_held)
);

>>> verif/frame_rate_window_stats_tb.sv
// testbench for the frame rate window statistics block: directed and random frame and clear beats
module frame_rate_window_stats_tb;
  import frws_pkg::*;

  localparam int WIN = 64;
  localparam int LIMIT_CYCLES = 2000000;

  typedef struct {
    logic        opcode;
    logic [31:0] stamp;
  } frame_beat_t;

  typedef struct {
    logic [27:0] current_fps;
    logic [27:0] average_fps;
    logic [27:0] min_fps;
    logic [27:0] max_fps;
    logic [6:0]  samples_held;
  } rate_stats_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  frws_in_if  in_ch ();
  frws_out_if out_ch ();

  frame_rate_window_stats DUT (
    .clk (clk),
    .rst (rst),
    .in  (in_ch.sink),
    .out (out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [31:0] win_ring [WIN];
  int unsigned win_slot;
  int unsigned win_held;
  logic [37:0] win_sum;
  logic [31:0] last_stamp;
  logic [27:0] cur_rate;

  frame_beat_t pending_beats [$];
  rate_stats_t expected_stats [$];
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  bit quiet_drive = 1'b0;
  bit quiet_recv = 1'b0;
  bit in_taken = 1'b0;
  bit stall_req = 1'b0;
  bit stall_seen = 1'b0;
  int unsigned hold_off = 0;

  function automatic logic [27:0] rate_from(logic [31:0] iv);
    logic [63:0] q;
    q = 64'd256000000 / iv;
    return q[27:0];
  endfunction

  // update the window and work out the stats for one accepted beat
  function automatic rate_stats_t predict_stats(frame_beat_t b);
    rate_stats_t r;
    logic [31:0] iv;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [63:0] q;
    int unsigned idx;
    r = '{default: '0};
    if (b.opcode == OP_CLEAR) begin
      win_held = 0;
      win_slot = 0;
      win_sum = '0;
      cur_rate = '0;
    end else begin
      iv = b.stamp - last_stamp;
      if (iv != 0) begin
        cur_rate = rate_from(iv);
        if (win_held >= WIN) win_sum = win_sum - win_ring[win_slot];
        else win_held++;
        win_ring[win_slot] = iv;
        win_sum = win_sum + iv;
        win_slot = (win_slot + 1) % WIN;
      end
    end
    last_stamp = b.stamp;
    if (win_held > 0) begin
      lo = 32'hffff_ffff;
      hi = '0;
      for (int i = 0; i < win_held; i++) begin
        idx = (win_slot + WIN - 1 - i) % WIN;
        if (win_ring[idx] < lo) lo = win_ring[idx];
        if (win_ring[idx] > hi) hi = win_ring[idx];
      end
      q = (64'd256000000 * win_held) / win_sum;
      r.average_fps = q[27:0];
      r.min_fps = rate_from(hi);
      r.max_fps = rate_from(lo);
    end
    r.current_fps = cur_rate;
    r.samples_held = win_held[6:0];
    return r;
  endfunction

  // driver: offer the next queued beat once the last one is taken, idling at random
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (pending_beats.size() != 0 && (quiet_drive || $urandom_range(99) >= 28)) begin
        in_ch.valid <= 1'b1;
        in_ch.opcode <= pending_beats[0].opcode;
        in_ch.timestamp_us <= pending_beats[0].stamp;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // accept on the rising edge, take from the driver queue and predict
  always @(posedge clk) begin
    frame_beat_t b;
    if (!rst && in_ch.valid && in_ch.ready) begin
      b = pending_beats[0];
      pending_beats.delete(0);
      expected_stats.insert(expected_stats.size(), predict_stats(b));
      in_taken <= 1'b1;
    end else begin
      in_taken <= 1'b0;
    end
  end

  // receiver ready, with random idling and one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off != 0) begin
      hold_off <= hold_off - 1;
      out_ch.ready <= 1'b0;
    end else if (stall_req && !stall_seen) begin
      stall_seen <= 1'b1;
      hold_off <= 400;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= quiet_recv || ($urandom_range(99) >= 28);
    end
  end

  // monitor: compare each result beat against the oldest expectation
  always @(posedge clk) begin
    rate_stats_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_stats.size() == 0) begin
        $error("result beat with nothing expected");
        err_count++;
      end else begin
        e = expected_stats[0];
        expected_stats.delete(0);
        if (out_ch.current_fps !== e.current_fps) begin
          $error("current_fps exp %0d got %0d", e.current_fps, out_ch.current_fps);
          err_count++;
        end
        if (out_ch.average_fps !== e.average_fps) begin
          $error("average_fps exp %0d got %0d", e.average_fps, out_ch.average_fps);
          err_count++;
        end
        if (out_ch.min_fps !== e.min_fps) begin
          $error("min_fps exp %0d got %0d", e.min_fps, out_ch.min_fps);
          err_count++;
        end
        if (out_ch.max_fps !== e.max_fps) begin
          $error("max_fps exp %0d got %0d", e.max_fps, out_ch.max_fps);
          err_count++;
        end
        if (out_ch.samples_held !== e.samples_held) begin
          $error("samples_held exp %0d got %0d", e.samples_held, out_ch.samples_held);
          err_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic void push_beat(logic op, logic [31:0] ts);
    frame_beat_t b;
    b.opcode = op;
    b.stamp = ts;
    pending_beats.insert(pending_beats.size(), b);
  endfunction

  // random interval: mostly small, sometimes zero, large or full range
  function automatic logic [31:0] pick_interval();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 5) return 32'd0;
    if (k < 15) return 32'd1 + $urandom_range(15);
    if (k < 75) return 32'd1000 + $urandom_range(99000);
    if (k < 92) return $urandom_range(32'h00ff_ffff);
    return $urandom();
  endfunction

  // stimulus
  initial begin
    logic [31:0] ts;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_FRAME;
    in_ch.timestamp_us = '0;
    out_ch.ready = 1'b0;
    win_slot = 0;
    win_held = 0;
    win_sum = '0;
    last_stamp = '0;
    cur_rate = '0;
    for (int i = 0; i < WIN; i++) win_ring[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: first event from zero, zero interval, extremes, wrap, clear
    push_beat(OP_FRAME, 32'd0);
    push_beat(OP_FRAME, 32'd1);
    push_beat(OP_FRAME, 32'd1);
    push_beat(OP_FRAME, 32'd2);
    push_beat(OP_FRAME, 32'hffff_ffff);
    push_beat(OP_FRAME, 32'h0000_0000);
    push_beat(OP_FRAME, 32'h8000_0000);
    push_beat(OP_FRAME, 32'h7fff_ffff);
    push_beat(OP_CLEAR, 32'hffff_fff0);
    push_beat(OP_FRAME, 32'hffff_fff0);
    push_beat(OP_FRAME, 32'h0000_0010);
    push_beat(OP_CLEAR, 32'h5555_5555);
    push_beat(OP_CLEAR, 32'haaaa_aaaa);
    push_beat(OP_FRAME, 32'haaaa_aaab);
    push_beat(OP_FRAME, 32'haaab_2c00);
    push_beat(OP_CLEAR, 32'd0);

    // fill well past the window so the oldest interval is overwritten
    ts = 32'd0;
    for (int i = 0; i < 90; i++) begin
      ts = ts + 32'd16000 + $urandom_range(2000);
      push_beat(OP_FRAME, ts);
    end

    // long stall on the receiver while the driver keeps offering
    quiet_drive = 1'b1;
    stall_req = 1'b1;
    while (pending_beats.size() > 60) @(posedge clk);
    quiet_drive = 1'b0;

    // random part: runs of frames with occasional clears
    for (int i = 0; i < 850; i++) begin
      if ($urandom_range(99) < 3) begin
        ts = $urandom();
        push_beat(OP_CLEAR, ts);
      end else begin
        ts = ts + pick_interval();
        push_beat(OP_FRAME, ts);
      end
      if (i == 400) begin
        while (pending_beats.size() != 0) @(posedge clk);
        quiet_drive = 1'b1;
        quiet_recv = 1'b1;
      end
      if (i == 550) begin
        while (pending_beats.size() != 0) @(posedge clk);
        quiet_drive = 1'b0;
        quiet_recv = 1'b0;
      end
    end

    while (pending_beats.size() != 0 || expected_stats.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (err_count == 0 && expected_stats.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/frws_pkg.sv
rtl/frws_in_if.sv
rtl/frws_out_if.sv
rtl/frws_ram.sv
rtl/frws_div.sv
rtl/frame_rate_window_stats.sv
rtl/frws_check.sv
verif/frame_rate_window_stats_tb.sv
